// File: rtl/core/rle_bitpack_hybrid_decoder_assert.svh
// Assertion macros shared by the command queue and the back end.
`ifndef RLE_BITPACK_HYBRID_DECODER_ASSERT_SVH
`define RLE_BITPACK_HYBRID_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rbd_pkg.sv
// Types, constants and helper functions of the hybrid stream decoder.
`default_nettype none
package rbd_pkg;

    localparam int C_MAX_BIT_WIDTH = 32;
    localparam int C_BUF_W         = C_MAX_BIT_WIDTH + 7;
    localparam int C_FIFO_DEPTH    = 4;

    localparam logic [1:0] KIND_RUN = 2'd0;
    localparam logic [1:0] KIND_LIT = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [31:0] ERR_LONG_HEADER = 32'd1;
    localparam logic [31:0] ERR_ZERO_GROUPS = 32'd2;
    localparam logic [31:0] ERR_MANY_GROUPS = 32'd3;

    localparam logic [63:0] C_GROUP_LIMIT = 64'd268435455;
    localparam logic [30:0] C_RUN_MAX     = 31'h7FFF_FFFF;
    localparam logic [3:0]  C_MAX_LIT_PER_BYTE = 4'd8;

    // Work unit handed from the front end to the back end.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] data;        // run value, error code, or literal byte
        logic [30:0] run_length;
        logic [5:0]  width;
        logic        lit_start;   // first byte of a literal run
        logic        lit_end;     // last byte of a literal run
    } t_cmd;

    function automatic logic [5:0] f_eff_width(input logic [5:0] raw);
        logic [5:0] w;
        if (raw == 6'd0) begin
            w = 6'd1;
        end else if (raw > 6'(C_MAX_BIT_WIDTH)) begin
            w = 6'(C_MAX_BIT_WIDTH);
        end else begin
            w = raw;
        end
        return w;
    endfunction

    function automatic logic [31:0] f_width_mask(input logic [5:0] w);
        logic [31:0] m;
        if (w >= 6'd32) begin
            m = '1;
        end else begin
            m = (32'd1 << w) - 32'd1;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/rbd_byte_if.sv
// Input byte channel: valid/ready handshake with one stream byte.
`default_nettype none
interface rbd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       start_of_page;

    modport source (output valid, output stream_byte, output start_of_page, input ready);
    modport sink (input valid, input stream_byte, input start_of_page, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rbd_res_if.sv
// Result channel: valid/ready handshake with one decoded result.
`default_nettype none
interface rbd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] value;
    logic [30:0] run_length;
    logic        last;

    modport source (output valid, output kind, output value, output run_length,
                    output last, input ready);
    modport sink (input valid, input kind, input value, input run_length,
                  input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rbd_cmd_fifo.sv
// Short command queue between the front end and the back end.
`default_nettype none
module rbd_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rbd_pkg::t_cmd i_push_cmd,
    output logic          o_not_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rbd_pkg::t_cmd o_head
);
    import rbd_pkg::*;
    `include "rle_bitpack_hybrid_decoder_assert.svh"

    localparam int PtrW = $clog2(C_FIFO_DEPTH);
    localparam int CntW = $clog2(C_FIFO_DEPTH + 1);

    t_cmd            r_mem [C_FIFO_DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_count;
    logic            push;
    logic            pop;

    assign o_not_full = (r_count != CntW'(C_FIFO_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_head     = r_mem[r_rd];
    assign push       = i_push && o_not_full;
    assign pop        = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= PtrW'(r_wr + 1'b1);
            end
            if (pop) begin
                r_rd <= PtrW'(r_rd + 1'b1);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `RBD_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CntW'(C_FIFO_DEPTH), "queue count above depth")
    `RBD_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, push && !pop,
        r_count == $past(r_count) + 1'b1, "queue count missed a push")
    `RBD_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, push == pop,
        $stable(r_count), "queue count moved without net transaction")

endmodule
`default_nettype wire

// File: rtl/core/rbd_front.sv
// Front end: parses run headers and repeat values, tags literal bytes, flags header errors.
`default_nettype none
module rbd_front #(
    parameter int MAX_HEADER_BYTES = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [5:0]    i_width,
    rbd_byte_if.sink      i_byte_if,
    output logic          o_push,
    output rbd_pkg::t_cmd o_cmd,
    input  logic          i_push_ready
);
    import rbd_pkg::*;

    localparam int AccW  = 7 * MAX_HEADER_BYTES;
    localparam int IndW  = (AccW > 64) ? 64 : AccW;
    localparam int SeenW = (MAX_HEADER_BYTES > 1) ? $clog2(MAX_HEADER_BYTES) : 1;
    localparam logic [SeenW-1:0] SeenLast = SeenW'(MAX_HEADER_BYTES - 1);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_REPEAT  = 2'd1;
    localparam logic [1:0] PH_LITERAL = 2'd2;
    localparam logic [1:0] PH_HALT    = 2'd3;

    logic [1:0]       r_phase, n_phase, b_phase;
    logic [AccW-1:0]  r_acc, n_acc, b_acc, full_acc;
    logic [SeenW-1:0] r_seen, n_seen, b_seen;
    logic [30:0]      r_run, n_run, b_run;
    logic [31:0]      r_vacc, n_vacc, b_vacc, full_vacc;
    logic [1:0]       r_vseen, n_vseen, b_vseen;
    logic [33:0]      r_left, n_left, b_left, left_dec;
    logic             r_first, n_first;

    logic             accept;
    logic             clear;
    logic [7:0]       in_byte;
    logic [63:0]      cnt64;
    logic [27:0]      groups;
    logic [33:0]      lit_bytes;
    logic [2:0]       value_bytes;

    assign i_byte_if.ready = i_push_ready;
    assign accept      = i_byte_if.valid && i_push_ready;
    assign clear       = i_byte_if.start_of_page;
    assign in_byte     = i_byte_if.stream_byte;
    assign value_bytes = 3'((7'(i_width) + 7'd7) >> 3);

    always_comb begin
        b_phase = clear ? PH_HEADER : r_phase;
        b_acc   = clear ? '0 : r_acc;
        b_seen  = clear ? '0 : r_seen;
        b_run   = clear ? '0 : r_run;
        b_vacc  = clear ? '0 : r_vacc;
        b_vseen = clear ? '0 : r_vseen;
        b_left  = clear ? '0 : r_left;

        full_acc = b_acc;
        for (int i = 0; i < MAX_HEADER_BYTES; i++) begin
            if (b_seen == SeenW'(i)) begin
                full_acc[7*i +: 7] = in_byte[6:0];
            end
        end
        cnt64 = 64'(full_acc[IndW-1:0]) >> 1;

        full_vacc = b_vacc;
        for (int k = 0; k < 4; k++) begin
            if (b_vseen == 2'(k)) begin
                full_vacc[8*k +: 8] = in_byte;
            end
        end
        left_dec = b_left - 34'd1;
    end

    assign groups    = cnt64[27:0];
    assign lit_bytes = 34'(groups) * 34'(i_width);

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_seen  = r_seen;
        n_run   = r_run;
        n_vacc  = r_vacc;
        n_vseen = r_vseen;
        n_left  = r_left;
        n_first = r_first;
        o_push  = 1'b0;
        o_cmd   = '0;
        o_cmd.width = i_width;

        if (accept) begin
            n_phase = b_phase;
            n_acc   = b_acc;
            n_seen  = b_seen;
            n_run   = b_run;
            n_vacc  = b_vacc;
            n_vseen = b_vseen;
            n_left  = b_left;
            case (b_phase)
                PH_HEADER: begin
                    if (in_byte[7]) begin
                        if (b_seen == SeenLast) begin
                            o_push     = 1'b1;
                            o_cmd.kind = KIND_ERR;
                            o_cmd.data = ERR_LONG_HEADER;
                            n_phase    = PH_HALT;
                        end else begin
                            n_acc  = full_acc;
                            n_seen = b_seen + 1'b1;
                        end
                    end else begin
                        n_acc  = '0;
                        n_seen = '0;
                        if (!full_acc[0]) begin
                            n_run   = (cnt64 > 64'(C_RUN_MAX)) ? C_RUN_MAX : cnt64[30:0];
                            n_vacc  = '0;
                            n_vseen = '0;
                            n_phase = PH_REPEAT;
                        end else if (cnt64 == 64'd0) begin
                            o_push     = 1'b1;
                            o_cmd.kind = KIND_ERR;
                            o_cmd.data = ERR_ZERO_GROUPS;
                            n_phase    = PH_HALT;
                        end else if (cnt64 >= C_GROUP_LIMIT) begin
                            o_push     = 1'b1;
                            o_cmd.kind = KIND_ERR;
                            o_cmd.data = ERR_MANY_GROUPS;
                            n_phase    = PH_HALT;
                        end else begin
                            n_left  = lit_bytes;
                            n_first = 1'b1;
                            n_phase = PH_LITERAL;
                        end
                    end
                end
                PH_REPEAT: begin
                    if (({1'b0, b_vseen} + 3'd1) >= value_bytes) begin
                        if (b_run != '0) begin
                            o_push           = 1'b1;
                            o_cmd.kind       = KIND_RUN;
                            o_cmd.data       = full_vacc & f_width_mask(i_width);
                            o_cmd.run_length = b_run;
                        end
                        n_vacc  = '0;
                        n_vseen = '0;
                        n_run   = '0;
                        n_phase = PH_HEADER;
                    end else begin
                        n_vacc  = full_vacc;
                        n_vseen = b_vseen + 1'b1;
                    end
                end
                PH_LITERAL: begin
                    o_push          = 1'b1;
                    o_cmd.kind      = KIND_LIT;
                    o_cmd.data      = {24'd0, in_byte};
                    o_cmd.lit_start = r_first && !clear;
                    o_cmd.lit_end   = (left_dec == '0);
                    n_first         = 1'b0;
                    n_left          = left_dec;
                    if (left_dec == '0) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                    // halted: drop bytes until the next page start
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_acc   <= '0;
            r_seen  <= '0;
            r_run   <= '0;
            r_vacc  <= '0;
            r_vseen <= '0;
            r_left  <= '0;
            r_first <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_seen  <= n_seen;
            r_run   <= n_run;
            r_vacc  <= n_vacc;
            r_vseen <= n_vseen;
            r_left  <= n_left;
            r_first <= n_first;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/rbd_back.sv
// Back end: unpacks literal bits and drives the registered result port.
`default_nettype none
module rbd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  rbd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    rbd_res_if.source     o_res_if
);
    import rbd_pkg::*;
    `include "rle_bitpack_hybrid_decoder_assert.svh"

    logic               r_act;
    logic [C_BUF_W-1:0] r_buf;
    logic [5:0]         r_held;
    logic [3:0]         r_cnt;
    logic [5:0]         r_w;
    logic               r_lit_end;

    logic               r_out_valid;
    logic [1:0]         r_out_kind;
    logic [31:0]        r_out_value;
    logic [30:0]        r_out_len;
    logic               r_out_last;

    logic               can_load;
    logic               more;
    logic               emit;
    logic [5:0]         held_after;
    logic [3:0]         cnt_after;
    logic               more_after;
    logic               act_done;
    logic               slot_free;
    logic               head_lit;
    logic               pop_lit;
    logic               pop_res;
    logic [C_BUF_W-1:0] base_buf;
    logic [5:0]         base_held;
    logic [C_BUF_W-1:0] in_buf;
    logic [5:0]         in_held;

    assign can_load   = !r_out_valid || o_res_if.ready;
    assign more       = r_act && (r_held >= r_w) && (r_cnt != C_MAX_LIT_PER_BYTE);
    assign emit       = more && can_load;
    assign held_after = r_held - r_w;
    assign cnt_after  = r_cnt + 4'd1;
    assign more_after = (held_after >= r_w) && (cnt_after != C_MAX_LIT_PER_BYTE);
    assign act_done   = r_act && (!more || (emit && !more_after));
    assign slot_free  = !r_act || act_done;
    assign head_lit   = (i_cmd.kind == KIND_LIT);
    assign pop_lit    = i_cmd_valid && slot_free && head_lit;
    assign pop_res    = i_cmd_valid && slot_free && !head_lit && !emit && can_load;
    assign o_pop      = pop_lit || pop_res;

    always_comb begin
        if (act_done && r_lit_end) begin
            base_buf  = '0;
            base_held = '0;
        end else if (emit) begin
            base_buf  = r_buf >> r_w;
            base_held = held_after;
        end else begin
            base_buf  = r_buf;
            base_held = r_held;
        end
        in_buf  = i_cmd.lit_start ? '0 : base_buf;
        in_held = i_cmd.lit_start ? '0 : base_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= 1'b0;
            r_buf     <= '0;
            r_held    <= '0;
            r_cnt     <= '0;
            r_w       <= 6'd1;
            r_lit_end <= 1'b0;
        end else if (pop_lit) begin
            r_act     <= 1'b1;
            r_buf     <= in_buf | (C_BUF_W'(i_cmd.data[7:0]) << in_held);
            r_held    <= in_held + 6'd8;
            r_cnt     <= '0;
            r_w       <= i_cmd.width;
            r_lit_end <= i_cmd.lit_end;
        end else begin
            r_act  <= r_act && !act_done;
            r_buf  <= base_buf;
            r_held <= base_held;
            if (emit) begin
                r_cnt <= cnt_after;
            end
        end
    end

    // Output register: one result per cycle, held while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit || pop_res) begin
            r_out_valid <= 1'b1;
        end else if (o_res_if.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind  <= KIND_LIT;
            r_out_value <= r_buf[31:0] & f_width_mask(r_w);
            r_out_len   <= 31'd1;
            r_out_last  <= !more_after;
        end else if (pop_res) begin
            r_out_kind  <= i_cmd.kind;
            r_out_value <= i_cmd.data;
            r_out_len   <= i_cmd.run_length;
            r_out_last  <= 1'b1;
        end
    end

    assign o_res_if.valid      = r_out_valid;
    assign o_res_if.kind       = r_out_kind;
    assign o_res_if.value      = r_out_value;
    assign o_res_if.run_length = r_out_len;
    assign o_res_if.last       = r_out_last;

    `RBD_ASSERT_NOW(a_held_bound, i_clk, i_rst_n, 1'b1, r_held <= 6'(C_BUF_W),
        "bit buffer overfilled")
    `RBD_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, r_act, r_cnt <= C_MAX_LIT_PER_BYTE,
        "too many literals from one byte")
    `RBD_ASSERT_NOW(a_one_source, i_clk, i_rst_n, pop_res, !emit,
        "run result collides with literal")
    `RBD_ASSERT_NEXT(a_emit_lands, i_clk, i_rst_n, emit || pop_res, r_out_valid,
        "result not presented")

endmodule
`default_nettype wire

// File: rtl/core/rle_bitpack_hybrid_decoder.sv
// Top level of the RLE / bit-packing hybrid stream decoder.
//
//   channel    dir  handshake        payload
//   i_byte_if  in   valid/ready      stream_byte[7:0], start_of_page
//   o_res_if   out  valid/ready      kind[1:0], value[31:0], run_length[30:0], last
//   cfg        in   i_cfg_we         i_cfg_wdata[5:0] = bit_width
//
// Header and repeat-value bytes are taken one per cycle while the queue has room.
// A literal byte yields up to eight results, one per cycle from the back-end unpacker
// while the sink accepts them; a run or an error yields a single result.
// Reset is synchronous and active low; it clears all decoding state, sets bit_width to 1.
// A four-entry command queue and the output register let either side stall alone.
`default_nettype none
module rle_bitpack_hybrid_decoder #(
    parameter int MAX_HEADER_BYTES = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    rbd_byte_if.sink   i_byte_if,
    rbd_res_if.source  o_res_if
);
    import rbd_pkg::*;

    logic [5:0] r_bit_width;
    logic [5:0] eff_width;
    logic       push;
    t_cmd       push_cmd;
    logic       not_full;
    logic       pop;
    logic       head_valid;
    t_cmd       head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_width <= 6'd1;
        end else if (i_cfg_we) begin
            r_bit_width <= i_cfg_wdata;
        end
    end

    assign eff_width = f_eff_width(r_bit_width);

    rbd_front #(
        .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_width      (eff_width),
        .i_byte_if    (i_byte_if),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .i_push_ready (not_full)
    );

    rbd_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_not_full (not_full),
        .i_pop      (pop),
        .o_valid    (head_valid),
        .o_head     (head)
    );

    rbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head),
        .o_pop       (pop),
        .o_res_if    (o_res_if)
    );

endmodule
`default_nettype wire
